// ===== sv/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   localparam int BYTE_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int OFS_W  = 11;
   localparam int CELL_W = 16;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_COLOR   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_SHOWN = 1'd1;

   localparam logic [BYTE_W-1:0] TEXT_COLOR_RESET = 8'd7;

   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [BYTE_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_READ  = 2'd1,
      OP_SET   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CNT_ZERO     = 2'd0,
      CNT_COLS     = 2'd1,
      CNT_LAST_ROW = 2'd2
   } cnt_sel_type;

   typedef struct packed {
      logic        take;
      logic        exec;
      logic        cnt_load;
      cnt_sel_type cnt_sel;
      logic        copy;
      logic        fill;
      logic        fill_zero;
      logic        result;
   } ctl_cmd_type;

   typedef struct packed {
      logic scroll;
      logic clear;
      logic cnt_last;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic [3:0]       pad;
      logic [COL_W-1:0] col_in;
      logic [ROW_W-1:0] row_in;
      logic [BYTE_W-1:0] byte_in;
   } req_data_type;

   typedef struct packed {
      logic              status;
      logic [OFS_W-1:0]  hw_cursor_offset;
      logic [COL_W-1:0]  cursor_col_out;
      logic [ROW_W-1:0]  cursor_row_out;
      logic [BYTE_W-1:0] cell_color;
      logic [BYTE_W-1:0] cell_char;
      logic [BYTE_W-1:0] echo_byte;
   } rsp_data_type;

endpackage

`default_nettype wire

// ===== sv/text_console_writer.sv =====
// For put, read and set, a transfer on rsp is loaded after the item passes the exec and
// result states; the result state waits while an untaken result is held. Items are taken
// one at a time. A line scroll and a screen clear both walk the store through its single
// write port before the result. Reset: synchronous; afterwards the screen store is zeroed
// one cell per cycle with req_tready low; csr writes are taken meanwhile.
`default_nettype none

module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // byte_in, row_in, col_in, zero pad
   input  wire  [tcw_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op
   input  wire  [tcw_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // echo_byte, cell_char, cell_color, cursor_row_out, cursor_col_out,
   // hw_cursor_offset, status
   output logic [tcw_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                              csr_we,
   input  wire  [tcw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [tcw_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tcw_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type stat;
   rsp_data_type  rsp_view;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tcw_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat)
   );

   assign rsp_view = rsp_data_type'(rsp_tdata);

`ifndef SYNTH
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_view.cursor_row_out < ROWS) && (rsp_view.cursor_col_out < COLUMNS))
      else $error("cursor outside the screen in result");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_view.status) |->
         (rsp_view.echo_byte == '0) && (rsp_view.cell_char == '0) &&
         (rsp_view.cell_color == '0))
      else $error("range error carries nonzero data");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while one is in work");

   a_result_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.result |-> stat.out_free)
      else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
`default_nettype none

module tcw_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire tcw_pkg::dp_status_type stat,
   output tcw_pkg::ctl_cmd_type   cmd
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_COPY,
      S_DRAIN,
      S_BLANK,
      S_CLEAR,
      S_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         S_INIT: begin
            cmd.fill      = 1'b1;
            cmd.fill_zero = 1'b1;
            if (stat.cnt_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            priority if (stat.scroll) begin
               cmd.cnt_load = 1'b1;
               cmd.cnt_sel  = CNT_COLS;
               state_in     = S_COPY;
            end else if (stat.clear) begin
               cmd.cnt_load = 1'b1;
               cmd.cnt_sel  = CNT_ZERO;
               state_in     = S_CLEAR;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_COPY: begin
            cmd.copy = 1'b1;
            if (stat.cnt_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            // The last copied cell is written back here.
            cmd.cnt_load = 1'b1;
            cmd.cnt_sel  = CNT_LAST_ROW;
            state_in     = S_BLANK;
         end
         S_BLANK: begin
            cmd.fill = 1'b1;
            if (stat.cnt_last) state_in = S_RESULT;
         end
         S_CLEAR: begin
            cmd.fill = 1'b1;
            if (stat.cnt_last) state_in = S_RESULT;
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.result = 1'b1;
               state_in   = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/tcw_dp.sv =====
`default_nettype none

module tcw_dp #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire  [tcw_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  wire  [tcw_pkg::REQ_USER_W-1:0]        req_tuser,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [tcw_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire                                   csr_we,
   input  wire  [tcw_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [tcw_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  wire tcw_pkg::ctl_cmd_type             cmd,
   output tcw_pkg::dp_status_type                stat
);
   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW1   = ROW_W + 1;
   localparam int CW1   = COL_W + 1;

   req_data_type req_view;

   op_type             op_ff;
   logic [BYTE_W-1:0]  byte_ff;
   logic [ROW_W-1:0]   row_req_ff;
   logic [COL_W-1:0]   col_req_ff;

   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [BYTE_W-1:0]  color_ff, color_in;
   logic               shown_ff, shown_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic               copy_pend_ff;
   logic [AW-1:0]      copy_addr_ff;
   logic [CELL_W-1:0]  rdata_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_ff, rsp_in;

   logic [CELL_W-1:0]  mem [CELLS];

   logic               in_range;
   logic [AW-1:0]      cur_base;
   logic [AW-1:0]      req_addr;
   logic               is_nl, is_cr, is_bs, is_draw;
   logic               at_last_row, at_last_col, line_feed;
   logic               ex_we;
   logic [AW-1:0]      ex_waddr;
   logic [CELL_W-1:0]  ex_wdata;
   logic [CELL_W-1:0]  fill_data;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [CELL_W-1:0]  mem_wdata;

   assign req_view = req_data_type'(req_tdata);

   assign in_range = ({1'b0, row_req_ff} < RW1'(ROWS)) && ({1'b0, col_req_ff} < CW1'(COLUMNS));
   assign cur_base = AW'(cur_row_ff) * AW'(COLUMNS) + AW'(cur_col_ff);
   assign req_addr = AW'(row_req_ff) * AW'(COLUMNS) + AW'(col_req_ff);

   assign is_nl       = (byte_ff == CH_NEWLINE);
   assign is_cr       = (byte_ff == CH_RETURN);
   assign is_bs       = (byte_ff == CH_BACKSPACE);
   assign is_draw     = !(is_nl || is_cr || is_bs);
   assign at_last_row = (cur_row_ff == ROW_W'(ROWS - 1));
   assign at_last_col = (cur_col_ff == COL_W'(COLUMNS - 1));
   assign line_feed   = (op_ff == OP_PUT) && (is_nl || (is_draw && at_last_col));

   assign stat.scroll   = line_feed && at_last_row;
   assign stat.clear    = (op_ff == OP_CLEAR);
   assign stat.cnt_last = (cnt_ff == AW'(CELLS - 1));
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   // Backspace blanks the cell left of the cursor; other drawn bytes land at the cursor.
   assign ex_we    = cmd.exec && (op_ff == OP_PUT) &&
                     (is_draw || (is_bs && (cur_col_ff != '0)));
   assign ex_waddr = is_bs ? cur_base - AW'(1) : cur_base;
   assign ex_wdata = {color_ff, (is_bs ? CH_SPACE : byte_ff)};
   assign fill_data = cmd.fill_zero ? '0 : {color_ff, CH_SPACE};

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ex_waddr;
      mem_wdata = ex_wdata;
      priority if (copy_pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = copy_addr_ff;
         mem_wdata = rdata_ff;
      end else if (cmd.fill) begin
         mem_we    = 1'b1;
         mem_waddr = cnt_ff;
         mem_wdata = fill_data;
      end else begin
         mem_we = ex_we;
      end
   end

   assign mem_re    = cmd.copy || (cmd.exec && (op_ff == OP_READ) && in_range);
   assign mem_raddr = cmd.copy ? cnt_ff : req_addr;

   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      if (cmd.exec) begin
         unique case (op_ff)
            OP_PUT: begin
               priority if (line_feed) begin
                  if (!at_last_row) cur_row_in = cur_row_ff + ROW_W'(1);
                  cur_col_in = '0;
               end else if (is_cr) begin
                  cur_col_in = '0;
               end else if (is_bs) begin
                  if (cur_col_ff != '0) cur_col_in = cur_col_ff - COL_W'(1);
               end else begin
                  cur_col_in = cur_col_ff + COL_W'(1);
               end
            end
            OP_READ: begin
            end
            OP_SET: begin
               if (in_range) begin
                  cur_row_in = row_req_ff;
                  cur_col_in = col_req_ff;
               end
            end
            OP_CLEAR: begin
               cur_row_in = '0;
               cur_col_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_load) begin
         unique case (cmd.cnt_sel)
            CNT_ZERO:     cnt_in = '0;
            CNT_COLS:     cnt_in = AW'(COLUMNS);
            CNT_LAST_ROW: cnt_in = AW'(CELLS - COLUMNS);
            default:      cnt_in = '0;
         endcase
      end else if (cmd.copy || cmd.fill) begin
         cnt_in = cnt_ff + AW'(1);
      end
   end

   always_comb begin
      color_in = color_ff;
      shown_in = shown_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TEXT_COLOR:   color_in = csr_wdata;
            CSR_CURSOR_SHOWN: shown_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_in.echo_byte        = (op_ff == OP_PUT) ? byte_ff : '0;
      rsp_in.cell_char        = ((op_ff == OP_READ) && in_range) ? rdata_ff[7:0] : '0;
      rsp_in.cell_color       = ((op_ff == OP_READ) && in_range) ? rdata_ff[15:8] : '0;
      rsp_in.cursor_row_out   = cur_row_ff;
      rsp_in.cursor_col_out   = cur_col_ff;
      rsp_in.hw_cursor_offset = shown_ff ? OFS_W'(cur_base) : OFS_W'(CELLS);
      rsp_in.status           = ((op_ff == OP_READ) || (op_ff == OP_SET)) && !in_range;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         color_ff     <= TEXT_COLOR_RESET;
         shown_ff     <= 1'b1;
         cnt_ff       <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         color_ff     <= color_in;
         shown_ff     <= shown_in;
         cnt_ff       <= cnt_in;
         copy_pend_ff <= cmd.copy;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff      <= op_type'(req_tuser);
         byte_ff    <= req_view.byte_in;
         row_req_ff <= req_view.row_in;
         col_req_ff <= req_view.col_in;
      end
      // A copied cell goes one row up on the cycle after its read.
      copy_addr_ff <= cnt_ff - AW'(COLUMNS);
      if (cmd.result) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   localparam int COLS        = DEF_COLUMNS;
   localparam int LINES       = DEF_ROWS;
   localparam int CELLS       = COLS * LINES;
   // Scrolls and clears each walk the whole store, so their number is capped.
   localparam int WALK_BUDGET = 140;
   localparam int PRINT_CAP   = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   wire                   rsp_tvalid;
   logic                  rsp_tready;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   text_console_writer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Console shadow: screen cells, cursor and the two registers.
   logic [CELL_W-1:0] screen_shadow [CELLS];
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;
   logic [BYTE_W-1:0] attr;
   logic              cursor_on;
   int                store_walks;

   rsp_data_type      console_results[$];
   int                mismatches;
   int                items_sent;
   int                burst_left;
   bit                tx_gaps;
   bit                rx_stalls;
   bit                hold_request;
   int                hold_left;
   int                pattern_age;
   logic [31:0]       stall_pattern;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void scroll_shadow();
      for (int i = 0; i < CELLS - COLS; i++) begin
         screen_shadow[i] = screen_shadow[i + COLS];
      end
      for (int c = 0; c < COLS; c++) begin
         screen_shadow[CELLS - COLS + c] = {attr, CH_SPACE};
      end
      store_walks++;
   endfunction

   function automatic void line_feed();
      if (cur_row >= LINES - 1) begin
         scroll_shadow();
         cur_row = ROW_W'(LINES - 1);
      end else begin
         cur_row = cur_row + 1'b1;
      end
      cur_col = '0;
   endfunction

   function automatic rsp_data_type console_step(op_type op, logic [BYTE_W-1:0] ch,
                                                 logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
      rsp_data_type res;
      logic         fits;
      int           here;
      res  = '0;
      fits = (r < LINES) && (c < COLS);
      here = int'(cur_row) * COLS + int'(cur_col);
      case (op)
         OP_PUT: begin
            res.echo_byte = ch;
            if (ch == CH_NEWLINE) begin
               line_feed();
            end else if (ch == CH_RETURN) begin
               cur_col = '0;
            end else if (ch == CH_BACKSPACE) begin
               if (cur_col > 0) begin
                  screen_shadow[here - 1] = {attr, CH_SPACE};
                  cur_col = cur_col - 1'b1;
               end
            end else begin
               screen_shadow[here] = {attr, ch};
               if (cur_col >= COLS - 1) line_feed();
               else cur_col = cur_col + 1'b1;
            end
         end
         OP_READ: begin
            if (fits) {res.cell_color, res.cell_char} = screen_shadow[int'(r) * COLS + int'(c)];
            else res.status = 1'b1;
         end
         OP_SET: begin
            if (fits) begin
               cur_row = r;
               cur_col = c;
            end else begin
               res.status = 1'b1;
            end
         end
         default: begin
            for (int i = 0; i < CELLS; i++) screen_shadow[i] = {attr, CH_SPACE};
            cur_row = '0;
            cur_col = '0;
            store_walks++;
         end
      endcase
      res.cursor_row_out   = cur_row;
      res.cursor_col_out   = cur_col;
      res.hw_cursor_offset = cursor_on ? OFS_W'(int'(cur_row) * COLS + int'(cur_col))
                                       : OFS_W'(CELLS);
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatches < PRINT_CAP) begin
         $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   task automatic check_field(string what, int got, int want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : result_check
      rsp_data_type got;
      rsp_data_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_data_type'(rsp_tdata);
         if (console_results.size() == 0) begin
            report_mismatch("transfer with nothing expected", int'(got.echo_byte), 0);
         end else begin
            want = console_results.pop_front();
            check_field("echo_byte", got.echo_byte, want.echo_byte);
            check_field("cell_char", got.cell_char, want.cell_char);
            check_field("cell_color", got.cell_color, want.cell_color);
            check_field("cursor_row_out", got.cursor_row_out, want.cursor_row_out);
            check_field("cursor_col_out", got.cursor_col_out, want.cursor_col_out);
            check_field("hw_cursor_offset", got.hw_cursor_offset, want.hw_cursor_offset);
            check_field("status", got.status, want.status);
         end
      end
   end

   // Receiver: a long hold on request, otherwise a rotating stall pattern.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else if (!rx_stalls) begin
         rsp_tready = 1'b1;
      end else begin
         if (pattern_age == 0) begin
            stall_pattern = $urandom;
            pattern_age   = $urandom_range(16, 96);
         end
         pattern_age--;
         rsp_tready    = stall_pattern[0] | stall_pattern[1];
         stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
      end
   end

   task automatic send_request(op_type op, logic [BYTE_W-1:0] ch,
                               logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
      req_data_type d;
      int           gap;
      // Once the budget is spent, anything that would walk the store becomes a read.
      if (store_walks >= WALK_BUDGET &&
          (op == OP_CLEAR ||
           (op == OP_PUT && cur_row == LINES - 1 &&
            (ch == CH_NEWLINE ||
             (ch != CH_RETURN && ch != CH_BACKSPACE && cur_col == COLS - 1))))) begin
         op = OP_READ;
      end
      d = '{pad: 4'd0, col_in: c, row_in: r, byte_in: ch};
      if (tx_gaps) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
               @(negedge clock);
               req_tvalid = 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         burst_left--;
      end
      @(negedge clock);
      req_tdata  = d;
      req_tuser  = op;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      console_results.push_back(console_step(op, ch, r, c));
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (console_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_TEXT_COLOR) attr = value;
      else cursor_on = value[0];
   endtask

   // A result leaves only once any scroll or clear has ended; the wait also lets a full store walk pass.
   task automatic set_console_mode(logic [BYTE_W-1:0] color, logic shown);
      wait_drained();
      repeat (CELLS + 8) @(posedge clock);
      write_csr(CSR_TEXT_COLOR, color);
      write_csr(CSR_CURSOR_SHOWN, CSR_DATA_W'(shown));
   endtask

   task automatic send_random_item();
      op_type            op;
      logic [BYTE_W-1:0] ch;
      logic [ROW_W-1:0]  r;
      logic [COL_W-1:0]  c;
      int                pick;
      pick = $urandom_range(0, 99);
      ch   = BYTE_W'($urandom);
      r    = ROW_W'($urandom);
      c    = COL_W'($urandom);
      if (pick < 60) begin
         op = OP_PUT;
         case ($urandom_range(0, 19))
            0:       ch = CH_NEWLINE;
            1:       ch = CH_RETURN;
            2, 3:    ch = CH_BACKSPACE;
            4, 5:    ;
            default: ch = BYTE_W'($urandom_range(32, 126));
         endcase
      end else if (pick < 78) begin
         op = OP_READ;
         if ($urandom_range(0, 3) != 0) begin
            r = $urandom_range(0, 1) ? cur_row : ROW_W'($urandom_range(0, LINES - 1));
            c = COL_W'($urandom_range(0, COLS - 1));
         end
      end else if (pick < 98) begin
         op = OP_SET;
         if ($urandom_range(0, 5) != 0) begin
            r = ROW_W'($urandom_range(0, LINES - 1));
            c = COL_W'($urandom_range(0, COLS - 1));
         end
      end else begin
         op = OP_CLEAR;
      end
      send_request(op, ch, r, c);
   endtask

   // A line of text typed at a chosen place, often on the bottom row, then read back.
   task automatic type_line();
      logic [ROW_W-1:0] r;
      int               len;
      r   = ($urandom_range(0, 3) == 0) ? ROW_W'(LINES - 1) : ROW_W'($urandom_range(0, LINES - 1));
      len = $urandom_range(1, 40);
      send_request(OP_SET, BYTE_W'($urandom), r, COL_W'($urandom_range(0, COLS - 1)));
      repeat (len) begin
         if ($urandom_range(0, 15) == 0) send_request(OP_PUT, CH_BACKSPACE, '0, '0);
         else send_request(OP_PUT, BYTE_W'($urandom_range(32, 126)), '0, '0);
      end
      if ($urandom_range(0, 1)) send_request(OP_PUT, CH_NEWLINE, '0, '0);
      send_request(OP_READ, '0, r, COL_W'($urandom_range(0, COLS - 1)));
      send_request(OP_READ, '0, cur_row, COL_W'($urandom_range(0, COLS - 1)));
   endtask

   task automatic run_mix(int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(0, 1)) type_line();
         else send_random_item();
      end
   endtask

   task automatic test_directed();
      send_request(OP_READ, '0, 5'd0, 7'd0);
      send_request(OP_READ, '0, 5'd24, 7'd79);
      send_request(OP_READ, '0, 5'd25, 7'd0);
      send_request(OP_READ, 8'hFF, 5'd31, 7'd127);
      send_request(OP_READ, '0, 5'd0, 7'd80);
      send_request(OP_SET, '0, 5'd25, 7'd5);
      send_request(OP_SET, '0, 5'd3, 7'd127);
      send_request(OP_PUT, 8'h48, '0, '0);
      send_request(OP_PUT, 8'h00, '0, '0);
      send_request(OP_PUT, 8'hFF, 5'd31, 7'd127);
      send_request(OP_PUT, CH_BACKSPACE, '0, '0);
      send_request(OP_PUT, CH_RETURN, '0, '0);
      send_request(OP_PUT, CH_BACKSPACE, '0, '0);
      send_request(OP_READ, '0, 5'd0, 7'd1);
      // Drawing into the bottom right corner wraps and scrolls.
      send_request(OP_SET, '0, 5'd24, 7'd79);
      send_request(OP_PUT, 8'h5A, '0, '0);
      send_request(OP_READ, '0, 5'd23, 7'd79);
      send_request(OP_READ, '0, 5'd24, 7'd0);
      send_request(OP_PUT, CH_NEWLINE, '0, '0);
      send_request(OP_READ, '0, 5'd22, 7'd79);
      send_request(OP_CLEAR, '0, '0, '0);
      send_request(OP_READ, '0, 5'd12, 7'd40);
      send_request(OP_SET, '0, 5'd0, 7'd79);
      send_request(OP_PUT, 8'h78, '0, '0);
      send_request(OP_READ, '0, 5'd0, 7'd79);
   endtask

   task automatic test_color_extremes();
      set_console_mode(8'h00, 1'b1);
      run_mix(300);
      set_console_mode(8'hFF, 1'b0);
      run_mix(300);
   endtask

   task automatic test_typing();
      set_console_mode(BYTE_W'($urandom), 1'($urandom));
      run_mix(400);
   endtask

   task automatic test_output_hold();
      tx_gaps      = 1'b0;
      hold_request = 1'b1;
      repeat (40) send_random_item();
      tx_gaps = 1'b1;
   endtask

   task automatic test_sender_pause();
      run_mix(30);
      wait_drained();
      run_mix(30);
   endtask

   task automatic test_back_to_back();
      tx_gaps   = 1'b0;
      rx_stalls = 1'b0;
      run_mix(150);
      tx_gaps   = 1'b1;
      rx_stalls = 1'b1;
   endtask

   task automatic test_default_colors();
      set_console_mode(TEXT_COLOR_RESET, 1'b1);
      run_mix(300);
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      rsp_tready    = 1'b0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      mismatches    = 0;
      items_sent    = 0;
      burst_left    = 0;
      tx_gaps       = 1'b1;
      rx_stalls     = 1'b1;
      hold_request  = 1'b0;
      hold_left     = 0;
      pattern_age   = 0;
      stall_pattern = '1;
      store_walks   = 0;
      cur_row       = '0;
      cur_col       = '0;
      attr          = TEXT_COLOR_RESET;
      cursor_on     = 1'b1;
      for (int i = 0; i < CELLS; i++) screen_shadow[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_color_extremes();
      test_typing();
      test_output_hold();
      test_sender_pause();
      test_back_to_back();
      test_default_colors();

      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
sv/tcw_pkg.sv
sv/tcw_ctrl.sv
sv/tcw_dp.sv
sv/text_console_writer.sv
test/testbench.sv
